// File: hdl/fcull_pkg.sv
`default_nettype none
// ============================================================================
// fcull_pkg
// Shared types and constants of the frustum cull test: register indexes,
// action and verdict codes, datapath widths and the per-plane interface.
// ============================================================================
package fcull_pkg;

    // Field and datapath widths
    localparam int COORD_W   = 16;  // Q8.8 coordinate, Q1.14 normal, Q8.8 distance
    localparam int EXT_W     = 17;  // doubled center, doubled extent, |normal|
    localparam int PROD_W    = 2 * EXT_W;
    localparam int SUM_W     = 40;  // signed Q.22 distances and radii
    localparam int RAD_W     = 15;  // unsigned Q7.8 radius or tolerance
    localparam int ACTION_W  = 2;
    localparam int VERDICT_W = 2;
    localparam int PLANE_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PIPE_DEPTH = 4;  // operand, product, sum and flag stages

    // Fraction alignment: Q8.8 to Q.22, and again doubled for boxes
    localparam int ALIGN_SH     = 14;
    localparam int ALIGN_BOX_SH = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_FAR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd6;

    localparam logic [RAD_W-1:0] TOLERANCE_RESET = 15'd1;

    // Action codes; the reserved code behaves as a box
    localparam logic [ACTION_W-1:0] ACT_POINT    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SPHERE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BOX      = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_DISJOINT   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_INTERSECTS = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_CONTAINS   = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_UNUSED     = 2'd3;

    // Object operands shared by all plane lanes
    typedef struct packed {
        logic signed [EXT_W-1:0] cx;   // center (doubled for boxes)
        logic signed [EXT_W-1:0] cy;
        logic signed [EXT_W-1:0] cz;
        logic signed [EXT_W-1:0] ex;   // doubled extent, boxes only
        logic signed [EXT_W-1:0] ey;
        logic signed [EXT_W-1:0] ez;
        logic                    is_box;
        logic [RAD_W-1:0]        rad;  // sphere radius or point tolerance
    } t_operand;

    // Per-plane classification
    typedef struct packed {
        logic disjoint;
        logic intersects;
    } t_plane_flags;

endpackage
`default_nettype wire

// File: hdl/fcull_plane.sv
`default_nettype none
// ============================================================================
// fcull_plane
// One plane lane: three-stage signed distance versus radius test.
// ============================================================================
module fcull_plane
    import fcull_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [PLANE_W-1:0] i_plane,
    input  wire t_operand           i_op,
    output t_plane_flags            o_flags
);

    logic signed [EXT_W-1:0]   nx, ny, nz;
    logic signed [EXT_W-1:0]   anx, any_n, anz;
    logic signed [COORD_W-1:0] pd;

    logic signed [PROD_W-1:0]  n_px, n_py, n_pz, n_qx, n_qy, n_qz;
    logic signed [30:0]        n_pd_term;
    logic signed [29:0]        n_rad_term;

    logic signed [PROD_W-1:0]  r_px, r_py, r_pz, r_qx, r_qy, r_qz;
    logic signed [30:0]        r_pd_term;
    logic signed [29:0]        r_rad_term;
    logic                      r_is_box;

    logic signed [SUM_W-1:0]   n_s, n_r, r_s, r_r;
    logic signed [SUM_W-1:0]   n_lo, n_hi;
    t_plane_flags              n_flags, r_flags;

    // Unpack the plane and take |n| for the box radius
    assign nx    = EXT_W'($signed(i_plane[15:0]));
    assign ny    = EXT_W'($signed(i_plane[31:16]));
    assign nz    = EXT_W'($signed(i_plane[47:32]));
    assign pd    = $signed(i_plane[63:48]);
    assign anx   = nx[EXT_W-1] ? -nx : nx;
    assign any_n = ny[EXT_W-1] ? -ny : ny;
    assign anz   = nz[EXT_W-1] ? -nz : nz;

    // Stage A: products
    assign n_px = nx * $signed(i_op.cx);
    assign n_py = ny * $signed(i_op.cy);
    assign n_pz = nz * $signed(i_op.cz);
    assign n_qx = anx * $signed(i_op.ex);
    assign n_qy = any_n * $signed(i_op.ey);
    assign n_qz = anz * $signed(i_op.ez);
    assign n_pd_term  = i_op.is_box ? $signed({pd, {ALIGN_BOX_SH{1'b0}}})
                                    : $signed({pd[COORD_W-1], pd, {ALIGN_SH{1'b0}}});
    assign n_rad_term = $signed({1'b0, i_op.rad, {ALIGN_SH{1'b0}}});

    // Stage B: distance and radius sums
    assign n_s = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz) + SUM_W'(r_pd_term);
    assign n_r = r_is_box ? (SUM_W'(r_qx) + SUM_W'(r_qy) + SUM_W'(r_qz))
                          : SUM_W'(r_rad_term);

    // Stage C: s < -r is disjoint, s <= r is intersects
    assign n_lo = r_s + r_r;
    assign n_hi = r_s - r_r;
    assign n_flags.disjoint   = n_lo[SUM_W-1];
    assign n_flags.intersects = n_hi[SUM_W-1] || (n_hi == '0);

    always_ff @(posedge i_clk) begin
        r_px       <= n_px;
        r_py       <= n_py;
        r_pz       <= n_pz;
        r_qx       <= n_qx;
        r_qy       <= n_qy;
        r_qz       <= n_qz;
        r_pd_term  <= n_pd_term;
        r_rad_term <= n_rad_term;
        r_is_box   <= i_op.is_box;
        r_s        <= n_s;
        r_r        <= n_r;
        r_flags    <= n_flags;
    end

    assign o_flags = r_flags;

endmodule
`default_nettype wire

// File: hdl/frustum_cull_test.sv
`default_nettype none
// ============================================================================
// frustum_cull_test
// Pipelined point, sphere and box classification against frustum planes.
// ============================================================================
// Usage:
//   Drive an object on i_action and the coordinate ports and raise start;
//   the object transfers at every rising edge where start is high and busy
//   is low. busy stays low, so one object transfers in every cycle.
//   Each object yields one verdict (disjoint, intersects, contains) on
//   o_verdict, marked by o_result_strobe for exactly one cycle. The
//   receiver cannot stall; verdicts leave in transfer order.
// Pipeline: the verdict passes the operand, product, sum, compare and
//   verdict registers in that order.
//   Throughput: one object per cycle, set by one lane of multipliers per
//   plane, all planes in parallel.
// Configuration: plane registers and the point tolerance are written
//   through i_cfg_we / i_cfg_index / i_cfg_data; unknown indexes and
//   planes beyond PLANE_COUNT drop. Write only while no object is in flight.
// Reset: synchronous, active low. Clears all valid bits, all planes to
//   zero and the tolerance to one LSB; in-flight objects are dropped.
// ============================================================================
module frustum_cull_test
    import fcull_pkg::*;
#(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ACTION_W-1:0]   i_action,
    input  wire logic [COORD_W-1:0]    i_first_x,
    input  wire logic [COORD_W-1:0]    i_first_y,
    input  wire logic [COORD_W-1:0]    i_first_z,
    input  wire logic [COORD_W-1:0]    i_second_x,
    input  wire logic [COORD_W-1:0]    i_second_y,
    input  wire logic [COORD_W-1:0]    i_second_z,
    input  wire logic [RAD_W-1:0]      i_sphere_radius,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [PLANE_W-1:0]    i_cfg_data,

    output logic                       o_result_strobe,
    output logic [VERDICT_W-1:0]       o_verdict
);

    logic                     accept;
    logic                     is_box;
    logic signed [EXT_W-1:0]  ax, ay, az, bx, by, bz;
    t_operand                 n_op, r_op;

    logic [PLANE_W-1:0]       r_plane [PLANE_COUNT];
    logic [RAD_W-1:0]         r_tolerance;

    logic [PIPE_DEPTH-1:0]    r_vld;
    t_plane_flags             w_flags [PLANE_COUNT];
    logic [PLANE_COUNT-1:0]   w_dis, w_int;
    logic [VERDICT_W-1:0]     n_verdict, r_verdict;
    logic                     r_strobe;

    // Never hold off the sender: the pipeline takes one object per cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Configuration: one register per plane lane plus the tolerance
    // ------------------------------------------------------------------
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cfg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else if (i_cfg_we && (i_cfg_index == CFG_PLANE_LEFT + CFG_IDX_W'(p))) begin
                r_plane[p] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOLERANCE_RESET;
        end else if (i_cfg_we && (i_cfg_index == CFG_TOLERANCE)) begin
            r_tolerance <= i_cfg_data[RAD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Operand stage: boxes use doubled center and doubled extent, so
    // nothing is rounded; points and spheres pass the center through.
    // The reserved action code is classified as a box.
    // ------------------------------------------------------------------
    assign is_box = (i_action == ACT_BOX) || (i_action == ACT_RESERVED);
    assign ax = EXT_W'($signed(i_first_x));
    assign ay = EXT_W'($signed(i_first_y));
    assign az = EXT_W'($signed(i_first_z));
    assign bx = EXT_W'($signed(i_second_x));
    assign by = EXT_W'($signed(i_second_y));
    assign bz = EXT_W'($signed(i_second_z));

    always_comb begin
        n_op.is_box = is_box;
        n_op.cx     = is_box ? ax + bx : ax;
        n_op.cy     = is_box ? ay + by : ay;
        n_op.cz     = is_box ? az + bz : az;
        // A box with max below min gives a negative extent; keep it as is
        n_op.ex     = bx - ax;
        n_op.ey     = by - ay;
        n_op.ez     = bz - az;
        n_op.rad    = (i_action == ACT_SPHERE) ? i_sphere_radius : r_tolerance;
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    // Valid bits track the operand, product, sum and flag stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], accept};
        end
    end

    // ------------------------------------------------------------------
    // Plane lanes, all in parallel
    // ------------------------------------------------------------------
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
        fcull_plane u_plane (
            .i_clk   (i_clk),
            .i_plane (r_plane[p]),
            .i_op    (r_op),
            .o_flags (w_flags[p])
        );
        assign w_dis[p] = w_flags[p].disjoint;
        assign w_int[p] = w_flags[p].intersects;
    end

    // Any disjoint plane wins, then any intersecting plane
    always_comb begin
        if (|w_dis) begin
            n_verdict = VERDICT_DISJOINT;
        end else if (|w_int) begin
            n_verdict = VERDICT_INTERSECTS;
        end else begin
            n_verdict = VERDICT_CONTAINS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign o_result_strobe = r_strobe;
    assign o_verdict       = r_verdict;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(PIPE_DEPTH+1) o_result_strobe)
        else $error("transfer did not produce a verdict on time");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(accept, PIPE_DEPTH+1))
        else $error("verdict strobe without a matching transfer");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_verdict != VERDICT_UNUSED))
        else $error("unused verdict code delivered");

    a_disjoint_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_DEPTH-1] && (w_dis != '0)) |=> (o_verdict == VERDICT_DISJOINT))
        else $error("disjoint plane lost in verdict merge");

endmodule
`default_nettype wire
